// ----- rtl/pfu_pkg.sv -----
// Shared types, widths and codes for the particle filter update and resample unit.
`default_nettype none
package pfu_pkg;

	localparam int unsigned NUM_PARTICLES_DEF   = 128;
	localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned IDX_W   = 7;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned WGT_W   = 17;
	localparam int unsigned UNI_W   = 16;
	localparam int unsigned CTR_W   = 18;
	localparam int unsigned ITV_W   = 24;
	localparam int unsigned BETA_W  = 19;
	localparam int unsigned CFG_W   = 24;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CTR_W-1:0] INIT_CENTER_RST = 18'd32768;
	localparam logic [ITV_W-1:0] INV_TWO_VAR_RST = 24'd3276800;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_CENTER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_TWO_VAR = 1'd1;

	// shared multiplier and divider sizes
	localparam int unsigned MUL_A_W  = 40;
	localparam int unsigned MUL_B_W  = 32;
	localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int unsigned DIV_STEPS = WGT_W - 1;
	localparam int unsigned DIV_CNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INIT    = 3'd0,
		OP_PROP    = 3'd1,
		OP_OBSERVE = 3'd2,
		OP_DRAW    = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_PROP_RD,
		ST_PROP_WR,
		ST_READ,
		ST_READ_OUT,
		ST_OBS_RD,
		ST_OBS_X,
		ST_OBS_D,
		ST_OBS_SQ,
		ST_OBS_T,
		ST_OBS_K,
		ST_OBS_L,
		ST_NRM_RD,
		ST_NRM_GO,
		ST_NRM_WAIT,
		ST_MAX_RD,
		ST_MAX_CMP,
		ST_BETA_MUL,
		ST_BETA_ADD,
		ST_WHEEL_RD,
		ST_WHEEL_CMP,
		ST_DRAW_POS,
		ST_DRAW_WR,
		ST_COMMIT_RD,
		ST_COMMIT_WR,
		ST_RESP
	} st_t;

	// divider request
	typedef struct packed {
		logic             start;
		logic [WGT_W-1:0] num;
	} div_req_t;

	// divider status
	typedef struct packed {
		logic             done;
		logic [WGT_W-1:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/pfu_mul.sv -----
// Shared registered multiplier used by the sequencer for every product.
`default_nettype none
module pfu_mul (
	input  wire logic                        clk,
	input  wire logic [pfu_pkg::MUL_A_W-1:0] a,
	input  wire logic [pfu_pkg::MUL_B_W-1:0] b,
	output logic      [pfu_pkg::MUL_P_W-1:0] prod_q
);
	import pfu_pkg::*;

	// register the product every cycle
	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule
`default_nettype wire

// ----- rtl/pfu_div.sv -----
// Restoring divider, one quotient bit per cycle, for weight normalization.
`default_nettype none
module pfu_div #(
	parameter int unsigned DEN_W = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfu_pkg::div_req_t req,
	input  wire logic [DEN_W-1:0]  den,
	output pfu_pkg::div_rsp_t      rsp
);
	import pfu_pkg::*;

	logic [DEN_W-1:0]     rem_q;
	logic [WGT_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_W-1:0]     num_ext;
	logic                 first_ge;
	logic [DEN_W:0]       rem2;
	logic                 step_ge;

	assign num_ext  = DEN_W'(req.num);
	assign first_ge = num_ext >= den;
	assign rem2     = {rem_q, 1'b0};
	assign step_ge  = rem2 >= {1'b0, den};

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= first_ge ? (num_ext - den) : num_ext;
			quo_q <= {{(WGT_W-1){1'b0}}, first_ge};
		end else if (busy_q) begin
			rem_q <= step_ge ? DEN_W'(rem2 - {1'b0, den}) : rem2[DEN_W-1:0];
			quo_q <= {quo_q[WGT_W-2:0], step_ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
`default_nettype wire

// ----- rtl/particle_filter_update_resample_unit.sv -----
// Top level: sequencer, particle stores and result register of the particle filter unit.
//
// Input words arrive on in_valid/in_stall with op, index, noise, obs_y and uniform;
// a word is taken when in_valid is high and in_stall is low. Each word returns
// exactly one result word on out_valid/out_stall (position, weight, done_res,
// status). One word is worked on at a time: in_stall stays high from the cycle
// after acceptance until its result has been loaded into the output register.
// Work per operation, done in turn on the stores and the shared multiplier
// and serial divider:
//   init, read, propagate: store accesses only;
//   observe: a likelihood chain for each particle, then normalization of each
//   particle, writing 1/N when the sum is zero, or else waiting on a divide
//   of its weight by the sum;
//   resample draw: the wheel steps, plus a max-weight scan on the first draw
//   of a pass and a commit on the last.
// After reset the weight store is cleared to 1/N in a pass over all particles
// during which in_stall is high; configuration writes are taken at any time.
// When out_stall holds the result, the block finishes the next word and then
// waits with in_stall high until the output register frees.
`default_nettype none
module particle_filter_update_resample_unit #(
	parameter int unsigned NUM_PARTICLES   = pfu_pkg::NUM_PARTICLES_DEF,
	parameter int unsigned EXP_TABLE_DEPTH = pfu_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pfu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pfu_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [pfu_pkg::OP_W-1:0]      op,
	input  wire logic [pfu_pkg::IDX_W-1:0]     index,
	input  wire logic signed [pfu_pkg::POS_W-1:0] noise,
	input  wire logic signed [pfu_pkg::POS_W-1:0] obs_y,
	input  wire logic [pfu_pkg::UNI_W-1:0]     uniform,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [pfu_pkg::POS_W-1:0]   position,
	output logic [pfu_pkg::WGT_W-1:0]          weight,
	output logic                               done_res,
	output logic                               status
);
	import pfu_pkg::*;

	localparam int unsigned AW    = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
	localparam int unsigned KW    = $clog2(EXP_TABLE_DEPTH);
	localparam int unsigned SUMW  = AW + WGT_W;
	localparam logic [WGT_W-1:0] UW = WGT_W'(65536 / NUM_PARTICLES);
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_PARTICLES - 1);
	localparam logic [AW-1:0] HALF_IDX = AW'(NUM_PARTICLES / 2);
	localparam longint Q30   = 64'sd1073741824;
	localparam longint EXP_H = (64'sd1 <<< 34) / EXP_TABLE_DEPTH;

	typedef logic [WGT_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

	// floor quotient of a non-negative value by a small count, shift and subtract
	function automatic longint div_small(input longint num, input longint den);
		longint q;
		longint rm;
		q  = 0;
		rm = 0;
		for (int b = 62; b >= 0; b--) begin
			rm = (rm <<< 1) | ((num >>> b) & 64'sd1);
			q  = q <<< 1;
			if (rm >= den) begin
				rm = rm - den;
				q  = q | 64'sd1;
			end
		end
		return q;
	endfunction

	// series for exp(-h), then repeated products give the table
	function automatic exp_tab_t build_exp_tab();
		longint   term;
		longint   r;
		longint   e;
		exp_tab_t tab;
		term = Q30;
		r    = Q30;
		e    = Q30;
		for (int n = 1; n <= 20; n++) begin
			term = div_small((term * EXP_H) >>> 30, longint'(n));
			r    = ((n & 1) != 0) ? (r - term) : (r + term);
		end
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			if (k > 0) begin
				e = (e * r + (64'sd1 <<< 29)) >>> 30;
			end
			tab[k] = WGT_W'((e + 64'sd8192) >>> 14);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	// saturate a 34-bit signed sum to 32 bits
	function automatic logic [POS_W-1:0] sat34(input logic [33:0] s);
		logic [POS_W-1:0] r;
		if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
			r = s[31:0];
		end else begin
			r = s[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return r;
	endfunction

	st_t st_q, st_d;

	// configuration
	logic [CTR_W-1:0] ctr_q;
	logic [ITV_W-1:0] itv_q;

	// latched input word
	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] idx_q;
	logic [POS_W-1:0] noise_q;
	logic [POS_W-1:0] y_q;
	logic [UNI_W-1:0] u_q;

	// sequencer state
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     draw_cnt_q;
	logic [AW-1:0]     wheel_q;
	logic [BETA_W-1:0] beta_q;
	logic [WGT_W-1:0]  max_w_q;
	logic [WGT_W-1:0]  mx_q;
	logic [SUMW-1:0]   sum_q;
	logic [POS_W-1:0]  ad_q;
	logic              zero_q;
	logic              stat_q;

	// staged result and output register
	logic [POS_W-1:0] res_pos_q;
	logic [WGT_W-1:0] res_w_q;
	logic             res_done_q;
	logic             res_stat_q;
	logic             out_valid_q;
	logic [POS_W-1:0] out_pos_q;
	logic [WGT_W-1:0] out_w_q;
	logic             out_done_q;
	logic             out_stat_q;

	// stores
	logic [POS_W-1:0] pos_mem [NUM_PARTICLES];
	logic [WGT_W-1:0] w_mem   [NUM_PARTICLES];
	logic [POS_W-1:0] np_mem  [NUM_PARTICLES];
	logic [POS_W-1:0] pos_rd_q;
	logic [WGT_W-1:0] w_rd_q;
	logic [POS_W-1:0] np_rd_q;

	logic             pos_we, w_we, np_we;
	logic [AW-1:0]    pos_wa, w_wa, np_wa;
	logic [AW-1:0]    pos_ra, w_ra, np_ra;
	logic [POS_W-1:0] pos_wd, np_wd;
	logic [WGT_W-1:0] w_wd;

	// shared units
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod_q;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// combinational helpers
	logic [AW-1:0]     a_idx;
	logic              idx_big;
	logic              ptr_last;
	logic              draw_last;
	logic [AW-1:0]     ptr_nxt;
	logic [33:0]       ctr_ext;
	logic [33:0]       init_sum;
	logic [33:0]       prop_sum;
	logic [POS_W-1:0]  pos_abs;
	logic [49:0]       d_val;
	logic [49:0]       d_abs;
	logic [KW-1:0]     k_idx;
	logic [WGT_W-1:0]  lik;
	logic [WGT_W-1:0]  cand;
	logic [WGT_W-1:0]  mx_nxt;
	logic              beta_gt;
	logic              out_free;

	assign a_idx     = AW'(idx_q);
	assign idx_big   = {25'd0, idx_q} >= 32'(NUM_PARTICLES);
	assign ptr_last  = ptr_q == LAST_IDX;
	assign draw_last = draw_cnt_q == LAST_IDX;
	assign ptr_nxt   = ptr_last ? '0 : ptr_q + AW'(1);

	assign ctr_ext  = {16'd0, ctr_q};
	assign init_sum = ((a_idx >= HALF_IDX) ? (~ctr_ext + 34'd1) : ctr_ext)
		+ {{2{noise_q[31]}}, noise_q};
	assign prop_sum = {{2{pos_rd_q[31]}}, pos_rd_q} + {{2{noise_q[31]}}, noise_q};

	assign pos_abs = pos_rd_q[31] ? (~pos_rd_q + 32'd1) : pos_rd_q;
	assign d_val   = {{18{y_q[31]}}, y_q} - {2'b00, prod_q[63:16]};
	assign d_abs   = d_val[49] ? (~d_val + 50'd1) : d_val;

	assign k_idx = prod_q[20 +: KW];
	assign lik   = (zero_q || ({{(32-KW){1'b0}}, k_idx} >= 32'(EXP_TABLE_DEPTH)))
		? '0 : EXP_TAB[k_idx];

	assign cand    = (st_q == ST_NRM_GO) ? UW : ((st_q == ST_NRM_WAIT) ? div_rsp.quo : w_rd_q);
	assign mx_nxt  = (cand > mx_q) ? cand : mx_q;
	assign beta_gt = beta_q > BETA_W'(w_rd_q);
	assign out_free = !out_valid_q || !out_stall;

	pfu_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	pfu_div #(
		.DEN_W (SUMW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.den    (sum_q),
		.rsp    (div_rsp)
	);

	// hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	// next state, store ports and shared unit operands
	always_comb begin
		st_d    = st_q;
		pos_ra  = a_idx;
		w_ra    = a_idx;
		np_ra   = ptr_q;
		pos_we  = 1'b0;
		pos_wa  = a_idx;
		pos_wd  = sat34(prop_sum);
		w_we    = 1'b0;
		w_wa    = a_idx;
		w_wd    = UW;
		np_we   = 1'b0;
		np_wa   = draw_cnt_q;
		np_wd   = pos_rd_q;
		mul_a   = '0;
		mul_b   = '0;
		div_req = '0;
		unique case (st_q)
			ST_CLEAR: begin
				w_we = 1'b1;
				w_wa = ptr_q;
				if (ptr_last) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					st_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (!idx_big) begin
					unique case (op_q)
						OP_INIT: begin
							pos_we = 1'b1;
							pos_wd = sat34(init_sum);
							w_we   = 1'b1;
							st_d   = ST_READ;
						end
						OP_PROP:    st_d = ST_PROP_RD;
						OP_OBSERVE: st_d = ST_OBS_RD;
						OP_DRAW:    st_d = (draw_cnt_q == '0) ? ST_MAX_RD : ST_BETA_MUL;
						default:    st_d = ST_READ;
					endcase
				end
			end
			ST_PROP_RD: st_d = ST_PROP_WR;
			ST_PROP_WR: begin
				pos_we = 1'b1;
				st_d   = ST_READ;
			end
			ST_READ:     st_d = ST_READ_OUT;
			ST_READ_OUT: st_d = ST_RESP;
			ST_OBS_RD: begin
				pos_ra = ptr_q;
				st_d   = ST_OBS_X;
			end
			ST_OBS_X: begin
				mul_a = MUL_A_W'(pos_abs);
				mul_b = pos_abs;
				st_d  = ST_OBS_D;
			end
			ST_OBS_D: st_d = ST_OBS_SQ;
			ST_OBS_SQ: begin
				mul_a = MUL_A_W'(ad_q);
				mul_b = ad_q;
				st_d  = ST_OBS_T;
			end
			ST_OBS_T: begin
				mul_a = prod_q[55:16];
				mul_b = MUL_B_W'(itv_q);
				st_d  = ST_OBS_K;
			end
			ST_OBS_K: begin
				mul_a = MUL_A_W'(prod_q[35:16]);
				mul_b = MUL_B_W'(EXP_TABLE_DEPTH);
				st_d  = ST_OBS_L;
			end
			ST_OBS_L: begin
				w_we = 1'b1;
				w_wa = ptr_q;
				w_wd = lik;
				st_d = ptr_last ? ST_NRM_RD : ST_OBS_RD;
			end
			ST_NRM_RD: begin
				w_ra = ptr_q;
				st_d = ST_NRM_GO;
			end
			ST_NRM_GO: begin
				if (sum_q == '0) begin
					w_we = 1'b1;
					w_wa = ptr_q;
					w_wd = UW;
					st_d = ptr_last ? ST_READ : ST_NRM_RD;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = w_rd_q;
					st_d          = ST_NRM_WAIT;
				end
			end
			ST_NRM_WAIT: begin
				if (div_rsp.done) begin
					w_we = 1'b1;
					w_wa = ptr_q;
					w_wd = div_rsp.quo;
					st_d = ptr_last ? ST_READ : ST_NRM_RD;
				end
			end
			ST_MAX_RD: begin
				w_ra = ptr_q;
				st_d = ST_MAX_CMP;
			end
			ST_MAX_CMP: st_d = ptr_last ? ST_BETA_MUL : ST_MAX_RD;
			ST_BETA_MUL: begin
				mul_a = MUL_A_W'(u_q);
				mul_b = MUL_B_W'({max_w_q, 1'b0});
				st_d  = ST_BETA_ADD;
			end
			ST_BETA_ADD: st_d = ST_WHEEL_RD;
			ST_WHEEL_RD: begin
				w_ra = wheel_q;
				st_d = ST_WHEEL_CMP;
			end
			ST_WHEEL_CMP: st_d = beta_gt ? ST_WHEEL_RD : ST_DRAW_POS;
			ST_DRAW_POS: begin
				pos_ra = wheel_q;
				w_ra   = wheel_q;
				st_d   = ST_DRAW_WR;
			end
			ST_DRAW_WR: begin
				np_we = 1'b1;
				st_d  = draw_last ? ST_COMMIT_RD : ST_RESP;
			end
			ST_COMMIT_RD: begin
				np_ra = ptr_q;
				st_d  = ST_COMMIT_WR;
			end
			ST_COMMIT_WR: begin
				pos_we = 1'b1;
				pos_wa = ptr_q;
				pos_wd = np_rd_q;
				w_we   = 1'b1;
				w_wa   = ptr_q;
				st_d   = ptr_last ? ST_RESP : ST_COMMIT_RD;
			end
			ST_RESP: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// particle stores
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_wa] <= pos_wd;
		end
		pos_rd_q <= pos_mem[pos_ra];
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[w_wa] <= w_wd;
		end
		w_rd_q <= w_mem[w_ra];
	end

	always_ff @(posedge clk) begin
		if (np_we) begin
			np_mem[np_wa] <= np_wd;
		end
		np_rd_q <= np_mem[np_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q       <= INIT_CENTER_RST;
			itv_q       <= INV_TWO_VAR_RST;
			ptr_q       <= '0;
			draw_cnt_q  <= '0;
			wheel_q     <= '0;
			beta_q      <= '0;
			max_w_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_INIT_CENTER) begin
					ctr_q <= cfg_data[CTR_W-1:0];
				end else if (cfg_index == CFG_INV_TWO_VAR) begin
					itv_q <= cfg_data[ITV_W-1:0];
				end
			end
			if (st_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLEAR, ST_OBS_L, ST_COMMIT_WR: ptr_q <= ptr_nxt;
				ST_MOD: begin
					ptr_q <= '0;
					if (!idx_big && op_q == OP_DRAW && draw_cnt_q == '0) begin
						wheel_q <= a_idx;
						beta_q  <= '0;
					end
				end
				ST_NRM_GO: begin
					if (sum_q == '0) begin
						ptr_q <= ptr_nxt;
						if (ptr_last) begin
							max_w_q <= mx_nxt;
						end
					end
				end
				ST_NRM_WAIT: begin
					if (div_rsp.done) begin
						ptr_q <= ptr_nxt;
						if (ptr_last) begin
							max_w_q <= mx_nxt;
						end
					end
				end
				ST_MAX_CMP: begin
					ptr_q <= ptr_nxt;
					if (ptr_last) begin
						max_w_q <= mx_nxt;
					end
				end
				ST_BETA_ADD: beta_q <= beta_q + BETA_W'(prod_q[33:16]);
				ST_WHEEL_CMP: begin
					if (beta_gt) begin
						beta_q  <= beta_q - BETA_W'(w_rd_q);
						wheel_q <= (wheel_q == LAST_IDX) ? '0 : wheel_q + AW'(1);
					end
				end
				ST_DRAW_WR: begin
					ptr_q      <= '0;
					draw_cnt_q <= draw_last ? '0 : draw_cnt_q + AW'(1);
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q    <= op;
					idx_q   <= index;
					noise_q <= noise;
					y_q     <= obs_y;
					u_q     <= uniform;
				end
			end
			ST_MOD: begin
				if (idx_big) begin
					idx_q <= idx_q - IDX_W'(NUM_PARTICLES);
				end
				sum_q  <= '0;
				mx_q   <= '0;
				stat_q <= 1'b0;
			end
			ST_OBS_D: begin
				ad_q   <= d_abs[31:0];
				zero_q <= d_abs[49:32] != '0;
			end
			ST_OBS_T: zero_q <= zero_q || (prod_q[63:56] != '0);
			ST_OBS_K: zero_q <= zero_q || (prod_q[63:36] != '0);
			ST_OBS_L: sum_q <= sum_q + SUMW'(lik);
			ST_NRM_GO: begin
				if (sum_q == '0) begin
					mx_q   <= mx_nxt;
					stat_q <= 1'b1;
				end
			end
			ST_NRM_WAIT: begin
				if (div_rsp.done) begin
					mx_q <= mx_nxt;
				end
			end
			ST_MAX_CMP: mx_q <= mx_nxt;
			ST_READ_OUT: begin
				res_pos_q  <= pos_rd_q;
				res_w_q    <= w_rd_q;
				res_done_q <= op_q == OP_OBSERVE;
				res_stat_q <= (op_q == OP_OBSERVE) && stat_q;
			end
			ST_DRAW_WR: begin
				res_pos_q  <= pos_rd_q;
				res_w_q    <= w_rd_q;
				res_done_q <= draw_last;
				res_stat_q <= 1'b0;
			end
			ST_RESP: begin
				if (out_free) begin
					out_pos_q  <= res_pos_q;
					out_w_q    <= res_w_q;
					out_done_q <= res_done_q;
					out_stat_q <= res_stat_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = st_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign position  = out_pos_q;
	assign weight    = out_w_q;
	assign done_res  = out_done_q;
	assign status    = out_stat_q;

endmodule
`default_nettype wire

// ----- rtl/pfu_chk.sv -----
// Port-level checker for the particle filter unit, bound to the top level.
`default_nettype none
module pfu_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [pfu_pkg::POS_W-1:0]     position,
	input wire logic [pfu_pkg::WGT_W-1:0]     weight,
	input wire logic                          done_res,
	input wire logic                          status
);
	import pfu_pkg::*;

	// one word at a time: stall right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in flight");

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(weight))
		else $error("stalled result changed");

	// normalized weights never exceed one
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> weight <= 17'd65536)
		else $error("weight above one");

	// zero-sum status only comes with a finished observe
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> done_res)
		else $error("status without done");

endmodule

bind particle_filter_update_resample_unit pfu_chk u_pfu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.position  (position),
	.weight    (weight),
	.done_res  (done_res),
	.status    (status)
);
`default_nettype wire
